@@ design/fss_pkg.sv @@
`default_nettype none

package fss_pkg;

  localparam int unsigned NPTS = 7;

  // Q1.12 unity
  localparam logic [12:0] ONE_Q12 = 13'd4096;

  // ceil(2^19 / 10): exact floor(n / 10) for n < 81920 via (n * RECIP10) >> 19
  localparam logic [15:0] RECIP10 = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  // Breakpoints in Q.4 pixels: -60 .. +60 step 20
  localparam logic signed [14:0] BP [0:NPTS-1] = '{
    -15'sd960, -15'sd640, -15'sd320, 15'sd0, 15'sd320, 15'sd640, 15'sd960
  };

  // Rule table, Q1.12. Row = error change, column = error.
  localparam logic [12:0] RULE_TAB [0:NPTS-1][0:NPTS-1] = '{
    '{13'd3072, 13'd3072, 13'd3072, 13'd3113, 13'd3154, 13'd3195, 13'd3277},
    '{13'd3072, 13'd3113, 13'd3113, 13'd3113, 13'd3277, 13'd3277, 13'd3277},
    '{13'd3072, 13'd3154, 13'd3277, 13'd3891, 13'd3482, 13'd3277, 13'd3113},
    '{13'd3113, 13'd3277, 13'd3686, 13'd4096, 13'd3686, 13'd3277, 13'd3154},
    '{13'd3113, 13'd3277, 13'd3482, 13'd3891, 13'd3277, 13'd3154, 13'd3072},
    '{13'd3277, 13'd3277, 13'd3277, 13'd3113, 13'd3113, 13'd3113, 13'd3113},
    '{13'd3277, 13'd3195, 13'd3154, 13'd3113, 13'd3072, 13'd3072, 13'd3072}
  };

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FUZZ,   // take item, fuzzify error and change
    OP_ROW,    // row blend over error weights, sel = {row, col}
    OP_COL,    // column blend over change weights, sel[0] = hi row
    OP_LOAD    // speed multiply, load output registers
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
  } cmd_t;

  // Membership of one value: neighboring points and weight of the lower one
  typedef struct packed {
    logic [2:0]  lo;
    logic [2:0]  hi;
    logic [12:0] wlo;
  } fuzz_t;

  function automatic fuzz_t fuzzify(input logic signed [14:0] x);
    fuzz_t       f;
    logic [2:0]  idx;
    logic [8:0]  d;
    logic [15:0] n;
    logic [31:0] q;
    idx = 3'd0;
    for (int i = NPTS - 1; i >= 1; i--) begin
      if (x < BP[i]) idx = 3'(i);
    end
    d = 9'(BP[idx] - x);
    // round(d * 4096 / 320) = floor((128 d + 5) / 10)
    n = {d, 7'd0} + 16'd5;
    q = 32'(n) * 32'(RECIP10);
    if (x < BP[0]) begin
      f.lo  = 3'd0;
      f.hi  = 3'd0;
      f.wlo = ONE_Q12;
    end else if (idx == 3'd0) begin
      // at or above the top point
      f.lo  = 3'(NPTS - 1);
      f.hi  = 3'(NPTS - 1);
      f.wlo = ONE_Q12;
    end else begin
      f.lo  = idx - 3'd1;
      f.hi  = idx;
      f.wlo = 13'(q >> RECIP_SHIFT);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ design/fss_ctrl.sv @@
`default_nettype none

module fss_ctrl import fss_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROW  = 2'd1;
  localparam logic [1:0] S_COL  = 2'd2;
  localparam logic [1:0] S_SPD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NONE;
    cmd_o.sel   = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_FUZZ;
          state_d  = S_ROW;
          cnt_d    = 2'd0;
        end
      end
      S_ROW: begin
        cmd_o.op = OP_ROW;
        cnt_d    = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_COL;
          cnt_d   = 2'd0;
        end
      end
      S_COL: begin
        cmd_o.op = OP_COL;
        cnt_d    = cnt_q + 2'd1;
        if (cnt_q[0]) begin
          state_d = S_SPD;
          cnt_d   = 2'd0;
        end
      end
      S_SPD: begin
        // hold here while the previous result is still unclaimed
        if (out_free) begin
          cmd_o.op    = OP_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/fss_datapath.sv @@
`default_nettype none

module fss_datapath import fss_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  input  wire signed [13:0]  line_error_i,
  input  wire                cfg_we_i,
  input  wire        [15:0]  cfg_wdata_i,
  output logic       [12:0]  speed_factor_o,
  output logic       [15:0]  motor_speed_o
);

  logic        [15:0] top_speed_q;
  logic signed [13:0] prev_q;

  fuzz_t       fe_q, fc_q;
  fuzz_t       fe_d, fc_d;
  logic signed [14:0] chg;

  logic [24:0] rlo_q, rhi_q;
  logic [36:0] sum_q;
  logic [12:0] factor_q;
  logic [12:0] speed_factor_q;
  logic [15:0] motor_speed_q;

  logic [12:0] we_hi, wc_hi;
  logic [2:0]  row_idx, col_idx;
  logic [24:0] mul_a;
  logic [15:0] mul_b;
  logic [40:0] mul_p;
  logic [36:0] sum_rnd;
  logic [28:0] spd_sum;
  logic [16:0] spd;

  assign chg  = {line_error_i[13], line_error_i} - {prev_q[13], prev_q};
  assign fe_d = fuzzify({line_error_i[13], line_error_i});
  assign fc_d = fuzzify(chg);

  assign we_hi = ONE_Q12 - fe_q.wlo;
  assign wc_hi = ONE_Q12 - fc_q.wlo;

  assign row_idx = cmd_i.sel[1] ? fc_q.hi : fc_q.lo;
  assign col_idx = cmd_i.sel[0] ? fe_q.hi : fe_q.lo;

  // one shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      OP_ROW: begin
        mul_a = 25'(RULE_TAB[row_idx][col_idx]);
        mul_b = 16'(cmd_i.sel[0] ? we_hi : fe_q.wlo);
      end
      OP_COL: begin
        mul_a = cmd_i.sel[0] ? rhi_q : rlo_q;
        mul_b = 16'(cmd_i.sel[0] ? wc_hi : fc_q.wlo);
      end
      OP_LOAD: begin
        mul_a = 25'(top_speed_q);
        mul_b = 16'(factor_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = 41'(mul_a) * 41'(mul_b);
  assign sum_rnd = sum_q + 37'(mul_p) + 37'd8388608;
  assign spd_sum = 29'(mul_p) + 29'd2048;
  assign spd     = spd_sum[28:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_speed_q <= 16'd4096;
      prev_q      <= '0;
    end else begin
      if (cfg_we_i) top_speed_q <= cfg_wdata_i;
      if (cmd_i.op == OP_FUZZ) prev_q <= line_error_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_FUZZ: begin
        fe_q <= fe_d;
        fc_q <= fc_d;
      end
      OP_ROW: begin
        unique case (cmd_i.sel)
          2'd0:    rlo_q <= 25'(mul_p);
          2'd1:    rlo_q <= rlo_q + 25'(mul_p);
          2'd2:    rhi_q <= 25'(mul_p);
          default: rhi_q <= rhi_q + 25'(mul_p);
        endcase
      end
      OP_COL: begin
        if (!cmd_i.sel[0]) sum_q    <= 37'(mul_p);
        else               factor_q <= 13'(sum_rnd >> 24);
      end
      OP_LOAD: begin
        speed_factor_q <= factor_q;
        motor_speed_q  <= spd[16] ? 16'hFFFF : spd[15:0];
      end
      default: ;
    endcase
  end

  assign speed_factor_o = speed_factor_q;
  assign motor_speed_o  = motor_speed_q;

endmodule

`default_nettype wire

@@ design/fuzzy_speed_scaler_core.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   line_error_i (s14, Q9.4 px)
// output    out        out_valid_o / out_stall_i speed_factor_o (u13 Q1.12),
//                                                motor_speed_o (u16 Q4.12)
// config    in         cfg_we_i                  cfg_wdata_i = top_speed
//
// One item at a time: accept (fuzzify), 4 row-blend steps, 2 column-blend
// steps and the speed multiply, all through the one shared multiplier.
// in_stall_o stays high until the result is loaded; the next item is taken after that.
// A waiting result sits in the output register; the next item is worked
// meanwhile and only its final load holds until the output is taken.
// Reset: previous error 0, top_speed 4096 (1.0), no result pending.
`default_nettype none

module fuzzy_speed_scaler_core import fss_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  // error samples
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire signed [13:0] line_error_i,
  // results
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic       [12:0] speed_factor_o,
  output logic       [15:0] motor_speed_o,
  // top speed register
  input  wire               cfg_we_i,
  input  wire        [15:0] cfg_wdata_i
);

  cmd_t cmd;

  // sequencer: accept, blend steps, output handoff
  fss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // fuzzifiers, rule table, shared multiply-accumulate, output registers
  fss_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .line_error_i   (line_error_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .speed_factor_o (speed_factor_o),
    .motor_speed_o  (motor_speed_o)
  );

endmodule

`default_nettype wire

@@ design/fss_checker.sv @@
`default_nettype none

module fss_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire [13:0] line_error_i,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [12:0] speed_factor_o,
  input wire [15:0] motor_speed_o
);

  // taking an item starts work: no second item next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while previous still in work");

  // a new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in work");

  // blended factor stays within the table span
  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_factor_o >= 13'd3072 && speed_factor_o <= 13'd4096)
    else $error("speed factor out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(speed_factor_o) && $stable(motor_speed_o))
    else $error("stalled result changed");

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(line_error_i))
    else $error("stalled input item changed");

endmodule

bind fuzzy_speed_scaler_core fss_checker u_fss_checker (.*);

`default_nettype wire
